// ----- rtl/btsum_pkg.sv -----
// ----------------------------------------------------------------------------
// btsum_pkg
// Shared sizes, register codes and item types of the boxcar time sum block.
// ----------------------------------------------------------------------------
`default_nettype none

package btsum_pkg;

    localparam int IMAGE_PIXELS = 4096;
    localparam int SAMPLE_BITS  = 16;

    localparam int SAMPLE_W = 16;
    localparam int PAIR_W   = 17;
    localparam int TRIPLE_W = 18;
    localparam int CFG_W    = 16;
    localparam int PIX_W    = (IMAGE_PIXELS > 1) ? $clog2(IMAGE_PIXELS) : 1;

    // sign extension from SAMPLE_BITS inside the 16-bit field
    localparam int EXT_SHIFT = (SAMPLE_BITS >= SAMPLE_W) ? 0 : SAMPLE_W - SAMPLE_BITS;

    // queue between front and back; depth is a power of two
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // a pixel address may be read again only after its previous write
    localparam int INFLIGHT_MAX = (IMAGE_PIXELS < Q_DEPTH) ? IMAGE_PIXELS : Q_DEPTH;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_IMAGES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIAL_COUNT = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] time_images;
        logic [CFG_W-1:0] trial_count;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [PIX_W-1:0]           pixel;
        logic                       width_two_valid;
        logic                       width_three_valid;
        logic                       cube_end;
    } cls_t;

    typedef struct packed {
        cls_t                       cls;
        logic signed [SAMPLE_W-1:0] prev_image;
        logic signed [PAIR_W-1:0]   prev_pair;
    } q_item_t;

    typedef struct packed {
        logic                       en;
        logic [PIX_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0] image;
        logic signed [PAIR_W-1:0]   pair;
    } ram_wr_t;

endpackage

`default_nettype wire

// ----- rtl/btsum_ram.sv -----
// ----------------------------------------------------------------------------
// btsum_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module btsum_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                                   aclk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/btsum_regs.sv -----
// ----------------------------------------------------------------------------
// btsum_regs
// APB register file: time images per trial and trial count.
// ----------------------------------------------------------------------------
`default_nettype none

module btsum_regs
    import btsum_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [CFG_W-1:0]     time_images_reg;
    logic [CFG_W-1:0]     trial_count_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic                 wr;

    assign pready = 1'b1;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_images_reg <= CFG_W'(1);
            trial_count_reg <= CFG_W'(1);
        end else if (wr) begin
            unique case (idx)
                REG_TIME_IMAGES: time_images_reg <= pwdata[CFG_W-1:0];
                REG_TRIAL_COUNT: trial_count_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TIME_IMAGES: prdata = APB_DATA_W'(time_images_reg);
            REG_TRIAL_COUNT: prdata = APB_DATA_W'(trial_count_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.time_images = time_images_reg;
    assign cfg.trial_count = trial_count_reg;

endmodule

`default_nettype wire

// ----- rtl/btsum_front.sv -----
// ----------------------------------------------------------------------------
// btsum_front
// Accepts samples, tracks pixel, time and trial, issues the history reads.
// ----------------------------------------------------------------------------
`default_nettype none

module btsum_front
    import btsum_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  cfg_t                            cfg,
    input  wire logic                       s_valid,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    output logic                            s_ready,
    input  wire logic [Q_CNT_W-1:0]         q_count,
    output logic                            rd_en,
    output logic [PIX_W-1:0]                rd_addr,
    output logic                            push,
    output cls_t                            push_cls
);

    logic [PIX_W-1:0] pixel_reg, pixel_next;
    logic [CFG_W-1:0] time_reg, time_next;
    logic [CFG_W-1:0] trial_reg, trial_next;
    logic             f1_valid_reg;
    cls_t             f1_reg;

    logic [Q_CNT_W:0]           inflight;
    logic                       accept;
    logic                       last_pixel, last_time, last_trial;
    logic signed [SAMPLE_W-1:0] sample_ext;
    cls_t                       cls;

    assign inflight = {1'b0, q_count} + (Q_CNT_W + 1)'(f1_valid_reg);
    assign s_ready  = inflight < (Q_CNT_W + 1)'(INFLIGHT_MAX);
    assign accept   = s_valid && s_ready;

    assign last_pixel = pixel_reg == PIX_W'(IMAGE_PIXELS - 1);
    assign last_time  = ({1'b0, time_reg} + (CFG_W + 1)'(1)) >= {1'b0, cfg.time_images};
    assign last_trial = ({1'b0, trial_reg} + (CFG_W + 1)'(1)) >= {1'b0, cfg.trial_count};

    assign sample_ext = (s_sample <<< EXT_SHIFT) >>> EXT_SHIFT;

    always_comb begin
        cls.sample            = sample_ext;
        cls.pixel             = pixel_reg;
        cls.width_two_valid   = time_reg != '0;
        cls.width_three_valid = time_reg > CFG_W'(1);
        cls.cube_end          = last_pixel && last_time && last_trial;
    end

    always_comb begin
        pixel_next = pixel_reg + PIX_W'(1);
        time_next  = time_reg;
        trial_next = trial_reg;
        if (last_pixel) begin
            pixel_next = '0;
            if (last_time) begin
                time_next  = '0;
                trial_next = last_trial ? '0 : trial_reg + CFG_W'(1);
            end else begin
                time_next = time_reg + CFG_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_reg    <= '0;
            time_reg     <= '0;
            trial_reg    <= '0;
            f1_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= accept;
            if (accept) begin
                pixel_reg <= pixel_next;
                time_reg  <= time_next;
                trial_reg <= trial_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_reg <= cls;
        end
    end

    assign rd_en    = accept;
    assign rd_addr  = pixel_reg;
    assign push     = f1_valid_reg;
    assign push_cls = f1_reg;

endmodule

`default_nettype wire

// ----- rtl/btsum_fifo.sv -----
// ----------------------------------------------------------------------------
// btsum_fifo
// Short queue of classified items with their history reads.
// ----------------------------------------------------------------------------
`default_nettype none

module btsum_fifo
    import btsum_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  q_item_t            push_item,
    input  wire logic          pop,
    output logic               head_valid,
    output q_item_t            head_item,
    output logic [Q_CNT_W-1:0] count
);

    q_item_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid = count_reg != '0;
    assign head_item  = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != Q_CNT_W'(Q_DEPTH))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + Q_CNT_W'(1))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

// ----- rtl/btsum_back.sv -----
// ----------------------------------------------------------------------------
// btsum_back
// Forms the three boxcar sums, writes the history back, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module btsum_back
    import btsum_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   head_valid,
    input  q_item_t                     head_item,
    output logic                        pop,
    output ram_wr_t                     wr,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [SAMPLE_W-1:0]  m_sum_width_one,
    output logic signed [PAIR_W-1:0]    m_sum_width_two,
    output logic                        m_width_two_valid,
    output logic signed [TRIPLE_W-1:0]  m_sum_width_three,
    output logic                        m_width_three_valid,
    output logic                        m_cube_end
);

    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] one_reg;
    logic signed [PAIR_W-1:0]   two_reg;
    logic                       two_valid_reg;
    logic signed [TRIPLE_W-1:0] three_reg;
    logic                       three_valid_reg;
    logic                       cube_end_reg;

    logic signed [SAMPLE_W-1:0] s;
    logic signed [PAIR_W-1:0]   pair;
    logic signed [TRIPLE_W-1:0] triple;

    assign pop = head_valid && (!m_valid_reg || m_ready);
    assign s   = head_item.cls.sample;

    assign pair = head_item.cls.width_two_valid
                ? PAIR_W'($signed(head_item.prev_image)) + PAIR_W'(s) : '0;
    assign triple = head_item.cls.width_three_valid
                  ? TRIPLE_W'($signed(head_item.prev_pair)) + TRIPLE_W'(s) : '0;

    assign wr.en    = pop;
    assign wr.addr  = head_item.cls.pixel;
    assign wr.image = s;
    assign wr.pair  = pair;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            one_reg         <= s;
            two_reg         <= pair;
            two_valid_reg   <= head_item.cls.width_two_valid;
            three_reg       <= triple;
            three_valid_reg <= head_item.cls.width_three_valid;
            cube_end_reg    <= head_item.cls.cube_end;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_sum_width_one     = one_reg;
    assign m_sum_width_two     = two_reg;
    assign m_width_two_valid   = two_valid_reg;
    assign m_sum_width_three   = three_reg;
    assign m_width_three_valid = three_valid_reg;
    assign m_cube_end          = cube_end_reg;

endmodule

`default_nettype wire

// ----- rtl/boxcar_time_sum_widths_one_to_three.sv -----
// ----------------------------------------------------------------------------
// boxcar_time_sum_widths_one_to_three
// Width one, two and three boxcar sums over time, per pixel of a data cube.
//
// Samples enter on the s_ channel in the order trial, time image, pixel,
// one per item. Each item gives one item on the m_ channel with the sample,
// the sum of the previous image and this one, and the sum of the last three
// images at the same pixel, each with its valid flag; sums stop at trial
// boundaries. m_cube_end marks the last sample of the cube.
// time_images (0x0) and trial_count (0x4) are set over APB, by the user only
// while idle; the block does not enforce it. Throughput is one item per
// cycle while the receiver takes items, set by the single read port of
// each history RAM, which is read in the front stage and written in the
// back stage. Reset clears the pixel, time and trial counters and sets
// both registers to 1; the history RAMs are not cleared, no read of an
// unwritten entry is used. When the receiver stalls, the output register
// and a 4-entry queue fill, then s_ready drops; no item is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module boxcar_time_sum_widths_one_to_three
    import btsum_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [CFG_ADDR_W-1:0]      paddr,
    input  wire logic [APB_DATA_W-1:0]      pwdata,
    output logic      [APB_DATA_W-1:0]      prdata,
    output logic                            pready,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_sum_width_one,
    output logic signed [PAIR_W-1:0]        m_sum_width_two,
    output logic                            m_width_two_valid,
    output logic signed [TRIPLE_W-1:0]      m_sum_width_three,
    output logic                            m_width_three_valid,
    output logic                            m_cube_end
);

    cfg_t               cfg;
    logic               rd_en;
    logic [PIX_W-1:0]   rd_addr;
    logic               push;
    cls_t               push_cls;
    q_item_t            push_item;
    logic               pop;
    logic               head_valid;
    q_item_t            head_item;
    logic [Q_CNT_W-1:0] q_count;
    ram_wr_t            wr;
    logic [SAMPLE_W-1:0] img_rdata;
    logic [PAIR_W-1:0]   pair_rdata;

    btsum_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    btsum_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_sample (s_sample),
        .s_ready  (s_ready),
        .q_count  (q_count),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .push     (push),
        .push_cls (push_cls)
    );

    btsum_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (IMAGE_PIXELS)
    ) u_image_ram (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.image),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (img_rdata)
    );

    btsum_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (IMAGE_PIXELS)
    ) u_pair_ram (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.pair),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (pair_rdata)
    );

    always_comb begin
        push_item.cls        = push_cls;
        push_item.prev_image = img_rdata;
        push_item.prev_pair  = pair_rdata;
    end

    btsum_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .count      (q_count)
    );

    btsum_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .head_valid          (head_valid),
        .head_item           (head_item),
        .pop                 (pop),
        .wr                  (wr),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_sum_width_one     (m_sum_width_one),
        .m_sum_width_two     (m_sum_width_two),
        .m_width_two_valid   (m_width_two_valid),
        .m_sum_width_three   (m_sum_width_three),
        .m_width_three_valid (m_width_three_valid),
        .m_cube_end          (m_cube_end)
    );

endmodule

`default_nettype wire
